// ===== design/sttk_pkg.sv =====
// Shared types, token codes and keyword tables of the source tokenizer.
`default_nettype none
package sttk_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int KW_MAX_CHARS_DEF = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int KW_COUNT = 15;
  localparam int KW_BITS = 64;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_NUM, M_NUMDOT, M_IDENT, M_STRING, M_COMMENT
  } mode_t;

  localparam logic [5:0] K_NUMBER     = 6'd0;
  localparam logic [5:0] K_STRING     = 6'd1;
  localparam logic [5:0] K_KW_BASE    = 6'd2;
  localparam logic [5:0] K_IDENT      = 6'd17;
  localparam logic [5:0] K_LPAREN     = 6'd18;
  localparam logic [5:0] K_RPAREN     = 6'd19;
  localparam logic [5:0] K_LBRACE     = 6'd20;
  localparam logic [5:0] K_RBRACE     = 6'd21;
  localparam logic [5:0] K_COMMA      = 6'd22;
  localparam logic [5:0] K_DOT        = 6'd23;
  localparam logic [5:0] K_ARROW_R    = 6'd24;
  localparam logic [5:0] K_MINUS      = 6'd25;
  localparam logic [5:0] K_PLUS       = 6'd26;
  localparam logic [5:0] K_COLON      = 6'd27;
  localparam logic [5:0] K_SEMI       = 6'd28;
  localparam logic [5:0] K_STAR       = 6'd29;
  localparam logic [5:0] K_EQUAL      = 6'd30;
  localparam logic [5:0] K_BANG_EQ    = 6'd31;
  localparam logic [5:0] K_BANG       = 6'd32;
  localparam logic [5:0] K_LESS_EQ    = 6'd33;
  localparam logic [5:0] K_ARROW_L    = 6'd34;
  localparam logic [5:0] K_LESS       = 6'd35;
  localparam logic [5:0] K_GREATER_EQ = 6'd36;
  localparam logic [5:0] K_GREATER    = 6'd37;
  localparam logic [5:0] K_SLASH      = 6'd38;
  localparam logic [5:0] K_END        = 6'd39;
  localparam logic [5:0] K_ILLEGAL    = 6'd40;
  localparam logic [5:0] K_NONE       = 6'd0;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_NUM_DOT  = 2'd1;
  localparam logic [1:0] E_UNTERM   = 2'd2;
  localparam logic [1:0] E_ILLEGAL  = 2'd3;

  // Keyword spellings, last character in the lowest byte.
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    64'h616e64,       64'h636f6e7374,   64'h66756e63,     64'h656c7365,
    64'h66616c7365,   64'h6966,         64'h6c6574,       64'h766f6964,
    64'h6f72,         64'h6e6f74,       64'h6f7574707574, 64'h72657475726e,
    64'h7265616c,     64'h626f6f6c,     64'h74727565
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd4, 4'd4, 4'd5, 4'd2, 4'd3, 4'd4,
    4'd2, 4'd3, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [23:0] len;
    logic [19:0] line;
    logic [15:0] col;
    logic [1:0]  err;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } pair_t;

  function automatic logic [5:0] kw_kind(input logic [KW_BITS-1:0] pfx,
                                         input logic [23:0] wlen);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (wlen == 24'(KW_LEN[i]) && pfx == KW_TEXT[i]) k = K_KW_BASE + 6'(i);
    end
    return k;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7b:   k = K_LBRACE;
      8'h7d:   k = K_RBRACE;
      8'h2c:   k = K_COMMA;
      8'h2e:   k = K_DOT;
      8'h2b:   k = K_PLUS;
      8'h3a:   k = K_COLON;
      8'h3b:   k = K_SEMI;
      8'h2a:   k = K_STAR;
      8'h3d:   k = K_EQUAL;
      8'h2f:   k = K_SLASH;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = K_NONE;
    if (p == 8'h2d && c == 8'h3e) k = K_ARROW_R;
    else if (p == 8'h3c && c == 8'h3d) k = K_LESS_EQ;
    else if (p == 8'h3c && c == 8'h2d) k = K_ARROW_L;
    else if (p == 8'h21 && c == 8'h3d) k = K_BANG_EQ;
    else if (p == 8'h3e && c == 8'h3d) k = K_GREATER_EQ;
    return k;
  endfunction

  function automatic logic [5:0] lone_op_kind(input logic [7:0] p);
    logic [5:0] k;
    case (p)
      8'h2d:   k = K_MINUS;
      8'h3c:   k = K_LESS;
      8'h21:   k = K_BANG;
      default: k = K_GREATER;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== design/sttk_front.sv =====
// Front end: scans one byte per cycle while acc is high and forms up to two tokens per word.
`default_nettype none
module sttk_front #(
  parameter int OFFSET_BITS = sttk_pkg::OFFSET_BITS_DEF,
  parameter int KW_MAX_CHARS = sttk_pkg::KW_MAX_CHARS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [7:0]    c,
  input  wire logic          endm,
  output logic               push,
  output sttk_pkg::pair_t    pair
);
  import sttk_pkg::*;

  localparam int PW = 8 * KW_MAX_CHARS;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, beg_r, beg_nxt, off_c;
  logic [19:0]            line_r, line_nxt, line_c;
  logic [15:0]            col_r, col_nxt, col_c;
  logic [PW-1:0]          pfx_r, pfx_nxt;
  logic [23:0]            wlen_r, wlen_nxt;
  logic [7:0]             pch_r, pch_nxt;
  logic                   nerr_r, nerr_nxt;

  logic       dig, alp, spc, lf, consumed;
  logic       ta_v, tb_v, fl_v;
  tok_t       ta, tb, fl;
  logic [5:0] k1, k2, wk;

  function automatic tok_t mk(input logic [5:0] kind,
                              input logic [OFFSET_BITS-1:0] st,
                              input logic [OFFSET_BITS-1:0] ln,
                              input logic [19:0] line, input logic [15:0] col,
                              input logic [1:0] err);
    tok_t t;
    t.kind  = kind;
    t.start = ((st >> 24) != '0) ? 24'hFFFFFF : 24'(st);
    t.len   = ((ln >> 24) != '0) ? 24'hFFFFFF : 24'(ln);
    t.line  = line;
    t.col   = col;
    t.err   = err;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      off_r  <= '0;
      beg_r  <= '0;
      line_r <= 20'd1;
      col_r  <= '0;
      pfx_r  <= '0;
      wlen_r <= '0;
      pch_r  <= '0;
      nerr_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      beg_r  <= beg_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      pfx_r  <= pfx_nxt;
      wlen_r <= wlen_nxt;
      pch_r  <= pch_nxt;
      nerr_r <= nerr_nxt;
    end
  end

  always_comb begin
    dig = (c >= 8'h30) && (c <= 8'h39);
    alp = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    spc = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    lf  = (c == 8'h0a);
    off_c  = (off_r != '1) ? off_r + 1'b1 : off_r;
    line_c = (lf && line_r != '1) ? line_r + 20'd1 : line_r;
    col_c  = lf ? 16'd1 : ((col_r != '1) ? col_r + 16'd1 : col_r);
    k1 = single_kind(c);
    k2 = pair_kind(pch_r, c);
    wk = (wlen_r > 24'(KW_MAX_CHARS)) ? K_IDENT : kw_kind(KW_BITS'(pfx_r), wlen_r);

    // Token pending in the current mode, closed before this byte.
    fl_v = 1'b0;
    fl   = mk(K_NUMBER, beg_r, off_r - beg_r, line_r, col_r, E_NONE);
    case (mode_r)
      M_OP: begin
        fl_v = 1'b1;
        fl.kind = lone_op_kind(pch_r);
      end
      M_NUM, M_NUMDOT: begin
        fl_v = 1'b1;
        fl.err = (nerr_r || mode_r == M_NUMDOT) ? E_NUM_DOT : E_NONE;
      end
      M_IDENT: begin
        fl_v = 1'b1;
        fl.kind = wk;
      end
      M_STRING: begin
        fl_v = endm;
        fl.kind = K_STRING;
        fl.err = E_UNTERM;
      end
      default: fl_v = 1'b0;
    endcase

    mode_nxt = mode_r;
    off_nxt  = off_r;
    beg_nxt  = beg_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    pfx_nxt  = pfx_r;
    wlen_nxt = wlen_r;
    pch_nxt  = pch_r;
    nerr_nxt = nerr_r;
    ta_v = 1'b0;
    tb_v = 1'b0;
    ta = fl;
    tb = mk(K_END, off_r, '0, line_r, col_r, E_NONE);
    consumed = 1'b0;

    if (acc) begin
      if (endm) begin
        // Close the pending token, then END, then start a fresh source.
        ta_v = fl_v;
        tb_v = 1'b1;
        mode_nxt = M_IDLE;
        off_nxt  = '0;
        beg_nxt  = '0;
        line_nxt = 20'd1;
        col_nxt  = '0;
        pfx_nxt  = '0;
        wlen_nxt = '0;
        pch_nxt  = '0;
        nerr_nxt = 1'b0;
      end else begin
        case (mode_r)
          M_OP: begin
            if (pch_r == 8'h2d && c == 8'h2d) begin
              consumed = 1'b1;
              mode_nxt = M_COMMENT;
            end else if (k2 != K_NONE) begin
              consumed = 1'b1;
              ta = mk(k2, beg_r, off_c - beg_r, line_c, col_c, E_NONE);
              ta_v = 1'b1;
              mode_nxt = M_IDLE;
            end else begin
              ta_v = 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_NUM, M_NUMDOT: begin
            nerr_nxt = nerr_r | (mode_r == M_NUMDOT && !dig);
            if (dig || c == 8'h2e) begin
              consumed = 1'b1;
              mode_nxt = (c == 8'h2e) ? M_NUMDOT : M_NUM;
            end else begin
              ta_v = 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_IDENT: begin
            if (alp || dig) begin
              consumed = 1'b1;
              if (wlen_r < 24'(KW_MAX_CHARS)) pfx_nxt = {pfx_r[PW-9:0], c};
              if (wlen_r != 24'hFFFFFF) wlen_nxt = wlen_r + 24'd1;
            end else begin
              ta_v = 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_STRING: begin
            consumed = 1'b1;
            if (c == 8'h22) begin
              ta = mk(K_STRING, beg_r, off_c - beg_r, line_c, col_c, E_NONE);
              ta_v = 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_COMMENT: begin
            consumed = 1'b1;
            if (lf) mode_nxt = M_IDLE;
          end
          default: mode_nxt = M_IDLE;
        endcase

        off_nxt  = off_c;
        line_nxt = line_c;
        col_nxt  = col_c;

        // Start a new token at this byte.
        if (!consumed) begin
          beg_nxt = off_r;
          tb = mk(k1, off_r, OFFSET_BITS'(1), line_c, col_c, E_NONE);
          if (k1 != K_NONE) begin
            tb_v = 1'b1;
          end else if (c == 8'h2d || c == 8'h3c || c == 8'h21 || c == 8'h3e) begin
            mode_nxt = M_OP;
            pch_nxt = c;
          end else if (c == 8'h22) begin
            mode_nxt = M_STRING;
          end else if (dig) begin
            mode_nxt = M_NUM;
            nerr_nxt = 1'b0;
          end else if (alp) begin
            mode_nxt = M_IDENT;
            pfx_nxt = PW'(c);
            wlen_nxt = 24'd1;
          end else if (!spc) begin
            tb.kind = K_ILLEGAL;
            tb.err = E_ILLEGAL;
            tb_v = 1'b1;
          end
        end
      end
    end

    push = ta_v | tb_v;
    pair.two = ta_v & tb_v;
    pair.t0 = ta_v ? ta : tb;
    pair.t1 = tb;
  end

endmodule
`default_nettype wire

// ===== design/sttk_queue.sv =====
// Short token-pair queue between the scanner and the output stage.
`default_nettype none
module sttk_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  sttk_pkg::pair_t      wr_pair,
  input  wire logic            pop,
  output sttk_pkg::pair_t      head,
  output logic                 empty,
  output logic                 full
);
  import sttk_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  pair_t         mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    empty  = (cnt_r == '0);
    full   = (cnt_r == (AW+1)'(QUEUE_DEPTH));
    head   = mem_r[rp_r];
    wp_nxt = wp_r + AW'(push);
    rp_nxt = rp_r + AW'(pop);
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_pair;
  end

endmodule
`default_nettype wire

// ===== design/sttk_back.sv =====
// Back end: unpacks token pairs into single output words with tlast.
`default_nettype none
module sttk_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  sttk_pkg::pair_t    head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sttk_pkg::tok_t     out_tok,
  output logic               out_last
);
  import sttk_pkg::*;

  logic v_r, v_nxt, half_r, half_nxt, last_r, last_nxt, load;
  tok_t tok_r, tok_nxt;

  always_comb begin
    load     = (!v_r || out_ready) && !empty;
    v_nxt    = v_r && !out_ready;
    half_nxt = half_r;
    last_nxt = last_r;
    tok_nxt  = tok_r;
    pop      = 1'b0;
    if (load) begin
      v_nxt = 1'b1;
      if (half_r) begin
        tok_nxt  = head.t1;
        last_nxt = 1'b1;
        half_nxt = 1'b0;
        pop      = 1'b1;
      end else begin
        tok_nxt  = head.t0;
        last_nxt = !head.two;
        half_nxt = head.two;
        pop      = !head.two;
      end
    end
    out_valid = v_r;
    out_tok   = tok_r;
    out_last  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      half_r <= 1'b0;
    end else begin
      v_r    <= v_nxt;
      half_r <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire

// ===== design/source_tokenizer_core.sv =====
// Top level of the streaming source tokenizer.
`default_nettype none
// Source tokenizer. Feed one source byte per word on the in_ channel (in_tuser
// high marks the end of the source and carries no byte); tokens leave on the out_
// channel, tlast set on the last token caused by an input word. The scanner takes
// one byte every cycle while its four-entry token-pair queue has room; a byte
// yields zero, one or two tokens. The output stage sends one token per cycle
// while out_tready is high, so a two-token byte leaves as two output words; the
// queue absorbs such bursts and is followed by the output register. After the
// end word all counters return to their reset values and a new source begins.
module source_tokenizer_core #(
  parameter int OFFSET_BITS  = sttk_pkg::OFFSET_BITS_DEF,
  parameter int KW_MAX_CHARS = sttk_pkg::KW_MAX_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic [0:0]  in_tuser,   // [0] end_marker
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // [5:0] token_kind, [29:6] token_start,
                                       // [53:30] token_length, [73:54] line_number,
                                       // [89:74] column_number, [91:90] error_code
  output logic             out_tlast   // last_of_run
);
  import sttk_pkg::*;

  logic  in_acc, q_push, q_pop, q_empty, q_full;
  pair_t f_pair, q_head;
  tok_t  o_tok;

  // Accept a word whenever the queue can take a pair.
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  sttk_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .KW_MAX_CHARS(KW_MAX_CHARS)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_acc),
    .c    (in_tdata),
    .endm (in_tuser[0]),
    .push (q_push),
    .pair (f_pair)
  );

  sttk_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_pair(f_pair),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  sttk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_tok  (o_tok),
    .out_last (out_tlast)
  );

  // Pack the token fields, lowest field first, padded to whole bytes.
  assign out_tdata = {4'b0, o_tok.err, o_tok.col, o_tok.line, o_tok.len,
                      o_tok.start, o_tok.kind};

  // No pair is written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("token queue overflow");

  // The end word always produces a pair whose final token is END.
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0]) |->
      (q_push && ((f_pair.two ? f_pair.t1.kind : f_pair.t0.kind) == K_END)))
    else $error("end word without END token");

  // END is always the last token of its run.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_tok.kind == K_END) |-> out_tlast)
    else $error("END token without tlast");

endmodule
`default_nettype wire
